### rtl/wpw_pkg.sv
// Shared types and constants for the waypoint progress watchdog.
package wpw_pkg;

  localparam int unsigned KIND_BITS  = 1;
  localparam int unsigned NOW_BITS   = 32;
  localparam int unsigned WPID_BITS  = 16;
  localparam int unsigned MODE_BITS  = 8;
  localparam int unsigned SPEED_BITS = 16;
  localparam int unsigned LIMIT_BITS = 20;
  localparam int unsigned CFG_IDX_BITS = 1;

  localparam logic [LIMIT_BITS-1:0] RUN_LIMIT_RST      = LIMIT_BITS'(3000);
  localparam logic [LIMIT_BITS-1:0] UPDATE_TIMEOUT_RST = LIMIT_BITS'(3000);

  typedef enum logic [KIND_BITS-1:0] {
    KIND_WAYPOINT = 1'b0,
    KIND_SENSOR   = 1'b1
  } wpw_kind_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RUN_LIMIT      = 1'b0,
    REG_UPDATE_TIMEOUT = 1'b1
  } wpw_reg_t;

  localparam logic [MODE_BITS-1:0] MODE_MANUAL = '0;

  typedef struct packed {
    logic                         kind;
    logic [NOW_BITS-1:0]          now_ms;
    logic [WPID_BITS-1:0]         waypoint_id;
    logic [MODE_BITS-1:0]         ecu_mode;
    logic signed [SPEED_BITS-1:0] vehicle_speed;
  } wpw_item_t;

  typedef struct packed {
    logic [LIMIT_BITS-1:0] run_limit_ms;
    logic [LIMIT_BITS-1:0] update_timeout_ms;
  } wpw_cfg_t;

  typedef struct packed {
    logic emit;
    logic status;
  } wpw_res_t;

endpackage

### rtl/waypoint_progress_watchdog.sv
// Top level of the waypoint progress watchdog: input stage, decision core, result register.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall  kind, now_ms, waypoint_id, ecu_mode, vehicle_speed
//   out_      output     out_valid / out_stall status
//   cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle while in_stall is low; an item is loaded into the input register when it is
// accepted, and when it advances the state and, if it gives a result, the result register update together.
// Synchronous active-low reset resets the watchdog state (marking it fresh) and sets both limits to 3000 ms.
// in_stall rises only when the input register holds an item with a result and the
// result register is full and stalled; items that give no result never wait.
module waypoint_progress_watchdog #(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned ID_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [wpw_pkg::KIND_BITS-1:0]         in_kind,
  input  logic [wpw_pkg::NOW_BITS-1:0]          in_now_ms,
  input  logic [wpw_pkg::WPID_BITS-1:0]         in_waypoint_id,
  input  logic [wpw_pkg::MODE_BITS-1:0]         in_ecu_mode,
  input  logic signed [wpw_pkg::SPEED_BITS-1:0] in_vehicle_speed,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_status,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wpw_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [wpw_pkg::LIMIT_BITS-1:0]        cfg_data
);
  import wpw_pkg::*;

  wpw_cfg_t  cfg;
  wpw_item_t s1_item_r;
  logic      s1_vld_r;
  wpw_res_t  res;
  logic      out_vld_r;
  logic      out_status_r;
  logic      out_free;
  logic      s1_adv;
  logic      fire;
  logic      in_take;

  wpw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wpw_core #(
    .TIME_BITS (TIME_BITS),
    .ID_BITS   (ID_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (s1_item_r),
    .cfg   (cfg),
    .fire  (fire),
    .res   (res)
  );

  assign out_free = !out_vld_r || !out_stall;
  assign s1_adv   = !res.emit || out_free;
  assign fire     = s1_vld_r && s1_adv;
  assign in_stall = s1_vld_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_take) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.kind          <= in_kind;
      s1_item_r.now_ms        <= in_now_ms;
      s1_item_r.waypoint_id   <= in_waypoint_id;
      s1_item_r.ecu_mode      <= in_ecu_mode;
      s1_item_r.vehicle_speed <= in_vehicle_speed;
    end
  end

  // hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire && res.emit) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.emit) begin
      out_status_r <= res.status;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_status = out_status_r;

endmodule

### rtl/wpw_cfg_regs.sv
// Configuration register file: run limit and update timeout.
module wpw_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wpw_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [wpw_pkg::LIMIT_BITS-1:0]       cfg_data,
  output wpw_pkg::wpw_cfg_t                    cfg
);
  import wpw_pkg::*;

  logic [LIMIT_BITS-1:0] run_limit_r;
  logic [LIMIT_BITS-1:0] upd_timeout_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_limit_r   <= RUN_LIMIT_RST;
      upd_timeout_r <= UPDATE_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (wpw_reg_t'(cfg_index))
        REG_RUN_LIMIT:      run_limit_r   <= cfg_data;
        REG_UPDATE_TIMEOUT: upd_timeout_r <= cfg_data;
      endcase
    end
  end

  assign cfg.run_limit_ms      = run_limit_r;
  assign cfg.update_timeout_ms = upd_timeout_r;

endmodule

### rtl/wpw_core.sv
// Watchdog state and per-item decision logic.
module wpw_core #(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned ID_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wpw_pkg::wpw_item_t item,
  input  wpw_pkg::wpw_cfg_t  cfg,
  input  logic               fire,
  output wpw_pkg::wpw_res_t  res
);
  import wpw_pkg::*;

  localparam int unsigned CW = (TIME_BITS > LIMIT_BITS) ? TIME_BITS : LIMIT_BITS;

  logic [ID_BITS-1:0]   cur_wp_r,     cur_wp_nxt;
  logic [TIME_BITS-1:0] last_upd_r,   last_upd_nxt;
  logic [TIME_BITS-1:0] run_start_r,  run_start_nxt;
  logic                 run_timing_r, run_timing_nxt;
  logic                 fresh_r,      fresh_nxt;
  logic                 err_r,        err_nxt;

  logic [TIME_BITS-1:0] now_t;
  logic [ID_BITS-1:0]   id_t;
  logic [TIME_BITS-1:0] since_upd;
  logic [TIME_BITS-1:0] since_run;
  logic                 moving;
  logic                 upd_expired;
  logic                 run_expired;

  assign now_t  = TIME_BITS'(item.now_ms);
  assign id_t   = ID_BITS'(item.waypoint_id);
  assign moving = (item.vehicle_speed != '0) && !item.vehicle_speed[SPEED_BITS-1];

  // wraps modulo 2^TIME_BITS
  assign since_upd = now_t - last_upd_r;
  assign since_run = now_t - run_start_r;

  assign upd_expired = CW'(cfg.update_timeout_ms) <= CW'(since_upd);
  assign run_expired = CW'(cfg.run_limit_ms) <= CW'(since_run);

  always_comb begin
    cur_wp_nxt     = cur_wp_r;
    last_upd_nxt   = last_upd_r;
    run_start_nxt  = run_start_r;
    run_timing_nxt = run_timing_r;
    fresh_nxt      = fresh_r;
    err_nxt        = err_r;
    res.emit       = 1'b0;
    res.status     = 1'b0;
    priority if (wpw_kind_t'(item.kind) == KIND_WAYPOINT) begin
      last_upd_nxt = now_t;
      if (id_t != cur_wp_r) begin
        cur_wp_nxt     = id_t;
        fresh_nxt      = 1'b1;
        err_nxt        = 1'b0;
        run_timing_nxt = 1'b0;
        res.emit       = 1'b1;
      end else begin
        fresh_nxt = 1'b0;
      end
    end else if (item.ecu_mode == MODE_MANUAL) begin
      run_timing_nxt = 1'b0;
    end else if (!moving) begin
      run_timing_nxt = 1'b0;
      res.emit       = 1'b1;
      res.status     = err_r;
    end else if (fresh_r) begin
      run_timing_nxt = 1'b0;
      if (upd_expired) begin
        fresh_nxt = 1'b0;
      end
    end else if (!run_timing_r) begin
      run_timing_nxt = 1'b1;
      run_start_nxt  = now_t;
    end else begin
      res.emit = 1'b1;
      if (run_expired) begin
        err_nxt    = 1'b1;
        res.status = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_wp_r     <= '0;
      last_upd_r   <= '0;
      run_start_r  <= '0;
      run_timing_r <= 1'b0;
      fresh_r      <= 1'b1;
      err_r        <= 1'b0;
    end else if (fire) begin
      cur_wp_r     <= cur_wp_nxt;
      last_upd_r   <= last_upd_nxt;
      run_start_r  <= run_start_nxt;
      run_timing_r <= run_timing_nxt;
      fresh_r      <= fresh_nxt;
      err_r        <= err_nxt;
    end
  end

endmodule

### rtl/wpw_checker.sv
// Port-level checks for the waypoint progress watchdog, bound to the top level.
module wpw_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_status,
  input logic cfg_ready
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("result beat dropped or changed while stalled");

  // a result needs an accepted input item or an earlier pending result
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(in_valid && !in_stall) && !$past(in_valid && !in_stall, 2) &&
    !$past(out_valid) |-> !out_valid)
    else $error("result beat without a source item");

  // input stalls only while an accepted item is still held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && in_stall |-> $past(in_valid && !in_stall) || $past(in_stall))
    else $error("input stalled with nothing held");

  // input stall only backs up from a stalled full result register
  a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result register can drain");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cfg_ready)
    else $error("configuration port not ready");

endmodule

bind waypoint_progress_watchdog wpw_checker u_wpw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_status (out_status),
  .cfg_ready  (cfg_ready)
);
